>>> src/rx_sequence_filter_link_quality_top_assert.svh
// ----------------------------------------------------------------------------
// rx_sequence_filter_link_quality_top_assert.svh
// Assertion macros shared by the receive sequence filter RTL.
// ----------------------------------------------------------------------------
`ifndef RX_SEQUENCE_FILTER_LINK_QUALITY_TOP_ASSERT_SVH
`define RX_SEQUENCE_FILTER_LINK_QUALITY_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RSF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication, disabled in reset
`define RSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/rsf_pkg.sv
// ----------------------------------------------------------------------------
// rsf_pkg
// Types, widths and codes of the receive sequence filter.
// ----------------------------------------------------------------------------
package rsf_pkg;

    localparam int DEF_NUM_CHANNELS = 256;

    localparam int TYPE_W     = 3;
    localparam int CHAN_W     = 8;
    localparam int SEQ_W      = 8;
    localparam int CFG_W      = 8;
    localparam int ACK_SEQ_W  = 16;
    localparam int PCT_W      = 8;
    localparam int CNT_W      = 32;
    localparam int CHAN_SPACE = 2 ** CHAN_W;

    localparam logic       KIND_REPORT  = 1'b1;
    localparam logic [2:0] FT_ACK       = 3'd1;
    localparam logic [2:0] FT_WITH_ACK  = 3'd4;

    localparam int WRAP_WINDOW   = -10;
    localparam int WRAP_DISTANCE = 256;
    localparam int PERCENT       = 100;

    // quotient never exceeds PERCENT, so seven bits are enough
    localparam int DIV_STEPS = $clog2(PERCENT + 1);
    localparam int DIV_W     = CNT_W + 1 + DIV_STEPS;

    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [PCT_W-1:0] PCT_NONE = -8'sd1;

    typedef struct packed {
        logic              is_report;
        logic              is_ack;
        logic              is_wack;
        logic [CHAN_W-1:0] chan;
        logic [SEQ_W-1:0]  seq;
    } t_cmd;

    typedef struct packed {
        logic                     accept;
        logic                     ack_out;
        logic [CHAN_W-1:0]        ack_chan;
        logic [ACK_SEQ_W-1:0]     ack_seq;
        logic [SEQ_W-1:0]         ack_echo;
        logic                     report_valid;
        logic signed [PCT_W-1:0]  rx_quality_pct;
        logic signed [PCT_W-1:0]  rx_useful_pct;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_RPT_OUT
    } t_exec_state;

    function automatic logic [CNT_W-1:0] f_sat_add(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

>>> src/rsf_ifs.sv
// ----------------------------------------------------------------------------
// rsf_ifs
// Valid/ready channels for frame header words and result words.
// ----------------------------------------------------------------------------
interface rsf_in_if import rsf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [TYPE_W-1:0] frame_type;
    logic [CHAN_W-1:0] chan_id;
    logic [SEQ_W-1:0]  seq_num;

    modport source (output valid, kind, frame_type, chan_id, seq_num, input ready);
    modport sink   (input valid, kind, frame_type, chan_id, seq_num, output ready);
endinterface

interface rsf_out_if import rsf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     accept;
    logic                     ack_out;
    logic [CHAN_W-1:0]        ack_chan;
    logic [ACK_SEQ_W-1:0]     ack_seq;
    logic [SEQ_W-1:0]         ack_echo;
    logic                     report_valid;
    logic signed [PCT_W-1:0]  rx_quality_pct;
    logic signed [PCT_W-1:0]  rx_useful_pct;

    modport source (output valid, accept, ack_out, ack_chan, ack_seq, ack_echo,
                    report_valid, rx_quality_pct, rx_useful_pct, input ready);
    modport sink   (input valid, accept, ack_out, ack_chan, ack_seq, ack_echo,
                    report_valid, rx_quality_pct, rx_useful_pct, output ready);
endinterface

>>> src/rx_sequence_filter_link_quality_top.sv
// ----------------------------------------------------------------------------
// rx_sequence_filter_link_quality_top
// Receive sequence filter with per-channel last sequence and link quality.
// ----------------------------------------------------------------------------
// i_in takes one word per frame header (kind 0) or report tick (kind 1);
// o_out gives exactly one result word for each.
// i_cfg_wr_en / i_cfg_wr_data write the ack channel offset; write it idle.
// In the execute stage a frame header first gets one sequence RAM read,
// then the compare, table write and result register load, which wait while
// o_out is stalled; execute takes a new word only once the last one is done.
// A report tick runs a shared restoring divider twice, one quotient bit a
// cycle, 7 bits each; the divider is skipped when nothing was received.
// A two-word queue sits between decode and execute, and the result register
// sits at the output, so input words are still taken while o_out is stalled
// until the queue fills.
// Reset clears counters, ack sequence, offset and per-channel seen bits;
// no clearing pass over the sequence RAM is needed.
// ----------------------------------------------------------------------------
module rx_sequence_filter_link_quality_top import rsf_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    rsf_in_if.sink            i_in,
    rsf_out_if.source         o_out
);

    logic w_f_valid;
    logic w_f_ready;
    t_cmd w_f_cmd;
    logic w_q_valid;
    logic w_q_ready;
    t_cmd w_q_cmd;

    rsf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_f_valid),
        .o_cmd       (w_f_cmd),
        .i_cmd_ready (w_f_ready)
    );

    rsf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_cmd   (w_f_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_cmd    (w_q_cmd)
    );

    rsf_exec #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_exec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_q_valid),
        .o_cmd_ready   (w_q_ready),
        .i_cmd         (w_q_cmd),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out         (o_out)
    );

endmodule

>>> src/rsf_ram.sv
// ----------------------------------------------------------------------------
// rsf_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/rsf_front.sv
// ----------------------------------------------------------------------------
// rsf_front
// Input stage: takes header and tick words and decodes them into commands.
// ----------------------------------------------------------------------------
module rsf_front import rsf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rsf_in_if.sink       i_in,
    output logic         o_cmd_valid,
    output t_cmd         o_cmd,
    input  logic         i_cmd_ready
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic w_take;

    assign i_in.ready = !r_valid || i_cmd_ready;
    assign w_take     = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (i_cmd_ready) begin
            n_valid = 1'b0;
        end
        if (w_take) begin
            n_valid         = 1'b1;
            n_cmd.is_report = (i_in.kind == KIND_REPORT);
            n_cmd.is_ack    = (i_in.frame_type == FT_ACK);
            n_cmd.is_wack   = (i_in.frame_type == FT_WITH_ACK);
            n_cmd.chan      = i_in.chan_id;
            n_cmd.seq       = i_in.seq_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

>>> src/rsf_queue.sv
// ----------------------------------------------------------------------------
// rsf_queue
// Short command FIFO between the decode stage and the execute stage.
// ----------------------------------------------------------------------------
module rsf_queue import rsf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_cmd  i_push_cmd,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_cmd  o_pop_cmd
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic [PTR_W-1:0]  n_wptr;
    logic [PTR_W-1:0]  n_rptr;
    logic [QCNT_W-1:0] n_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_push) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
        if (w_push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

endmodule

>>> src/rsf_exec.sv
// ----------------------------------------------------------------------------
// rsf_exec
// Execute stage: sequence table update, link counters, report divider and
// result register.
// ----------------------------------------------------------------------------
`include "rx_sequence_filter_link_quality_top_assert.svh"

module rsf_exec import rsf_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  t_cmd              i_cmd,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    rsf_out_if.source         o_out
);

    localparam int IDX_W   = $clog2(NUM_CHANNELS);
    localparam int DIFF_W  = SEQ_W + 2;
    localparam int STEP_W  = $clog2(DIV_STEPS);

    localparam logic signed [DIFF_W-1:0] WRAP_LO  = DIFF_W'(WRAP_WINDOW);
    localparam logic signed [DIFF_W-1:0] WRAP_ADD = DIFF_W'(WRAP_DISTANCE);

    typedef logic [IDX_W-1:0] t_idx_tab [CHAN_SPACE];

    function automatic t_idx_tab f_idx_tab();
        t_idx_tab tab;
        for (int i = 0; i < CHAN_SPACE; i++) begin
            tab[i] = IDX_W'(i % NUM_CHANNELS);
        end
        return tab;
    endfunction

    localparam t_idx_tab IDX_TAB = f_idx_tab();

    t_exec_state              r_state;
    t_exec_state              n_state;
    t_cmd                     r_cmd;
    t_cmd                     n_cmd;
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         n_idx;
    t_out                     r_out;
    t_out                     n_out;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [CFG_W-1:0]         r_ack_off;
    logic [CFG_W-1:0]         n_ack_off;
    logic [ACK_SEQ_W-1:0]     r_ack_num;
    logic [ACK_SEQ_W-1:0]     n_ack_num;
    logic [CNT_W-1:0]         r_miss_cnt;
    logic [CNT_W-1:0]         n_miss_cnt;
    logic [CNT_W-1:0]         r_useful_cnt;
    logic [CNT_W-1:0]         n_useful_cnt;
    logic [CNT_W-1:0]         r_useless_cnt;
    logic [CNT_W-1:0]         n_useless_cnt;
    logic                     r_seen [NUM_CHANNELS];

    logic [CNT_W:0]           r_recv;
    logic [CNT_W:0]           n_recv;
    logic [CNT_W-1:0]         r_useful;
    logic [CNT_W-1:0]         n_useful;
    logic [CNT_W-1:0]         r_miss;
    logic [CNT_W-1:0]         n_miss;
    logic [DIV_W-1:0]         r_rem;
    logic [DIV_W-1:0]         n_rem;
    logic [DIV_W-1:0]         r_dsh;
    logic [DIV_W-1:0]         n_dsh;
    logic [DIV_STEPS-1:0]     r_q;
    logic [DIV_STEPS-1:0]     n_q;
    logic [STEP_W-1:0]        r_bit;
    logic [STEP_W-1:0]        n_bit;
    logic                     r_pass;
    logic                     n_pass;
    logic signed [PCT_W-1:0]  r_qpct;
    logic signed [PCT_W-1:0]  n_qpct;
    logic signed [PCT_W-1:0]  r_upct;
    logic signed [PCT_W-1:0]  n_upct;

    logic                     w_pop;
    logic                     w_out_free;
    logic [IDX_W-1:0]         w_raddr;
    logic [SEQ_W-1:0]         w_prev;
    logic                     w_ram_we;
    logic                     w_seen_set;
    logic                     w_prev_seen;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [DIFF_W-1:0] w_qdiff;
    logic                     w_wrapped;
    logic                     w_fresh;
    logic [SEQ_W-1:0]         w_miss_inc;
    logic [CNT_W+1:0]         w_total;
    logic [DIV_W:0]           w_trial;
    logic                     w_take;

    rsf_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (NUM_CHANNELS)
    ) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_cmd.seq),
        .i_raddr (w_raddr),
        .o_rdata (w_prev)
    );

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    // sequence window
    assign w_prev_seen = r_seen[r_idx];
    assign w_diff      = $signed({2'b00, r_cmd.seq}) - $signed({2'b00, w_prev});
    assign w_wrapped   = (w_diff < WRAP_LO);
    assign w_qdiff     = w_wrapped ? (w_diff + WRAP_ADD) : w_diff;
    assign w_fresh     = !w_prev_seen || (w_diff > 0) || w_wrapped;
    assign w_miss_inc  = SEQ_W'(w_qdiff - DIFF_W'(1));

    assign w_total = {1'b0, r_recv} + {2'b00, r_miss};
    assign w_trial = {1'b0, r_rem} - {1'b0, r_dsh};
    assign w_take  = !w_trial[DIV_W];

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_idx         = r_idx;
        n_out         = r_out;
        n_out_valid   = r_out_valid;
        n_ack_off     = i_cfg_wr_en ? i_cfg_wr_data : r_ack_off;
        n_ack_num     = r_ack_num;
        n_miss_cnt    = r_miss_cnt;
        n_useful_cnt  = r_useful_cnt;
        n_useless_cnt = r_useless_cnt;
        n_recv        = r_recv;
        n_useful      = r_useful;
        n_miss        = r_miss;
        n_rem         = r_rem;
        n_dsh         = r_dsh;
        n_q           = r_q;
        n_bit         = r_bit;
        n_pass        = r_pass;
        n_qpct        = r_qpct;
        n_upct        = r_upct;
        w_raddr       = r_idx;
        w_ram_we      = 1'b0;
        w_seen_set    = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                w_raddr = IDX_TAB[i_cmd.chan];
                if (w_pop) begin
                    n_cmd = i_cmd;
                    n_idx = IDX_TAB[i_cmd.chan];
                    if (i_cmd.is_report) begin
                        n_recv        = {1'b0, r_useful_cnt} + {1'b0, r_useless_cnt};
                        n_useful      = r_useful_cnt;
                        n_miss        = r_miss_cnt;
                        n_miss_cnt    = '0;
                        n_useful_cnt  = '0;
                        n_useless_cnt = '0;
                        n_pass        = 1'b0;
                        n_state       = S_DIV_LOAD;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (w_out_free) begin
                    if (w_prev_seen && (w_qdiff > 0)) begin
                        n_miss_cnt   = f_sat_add(r_miss_cnt, CNT_W'(w_miss_inc));
                        n_useful_cnt = f_sat_add(r_useful_cnt, CNT_W'(1));
                    end else begin
                        n_useless_cnt = f_sat_add(r_useless_cnt, CNT_W'(1));
                    end
                    n_out = '0;
                    if (r_cmd.is_ack) begin
                        w_ram_we   = 1'b1;
                        w_seen_set = 1'b1;
                    end else begin
                        if (r_cmd.is_wack) begin
                            n_out.ack_out  = 1'b1;
                            n_out.ack_chan = r_cmd.chan + r_ack_off;
                            n_out.ack_seq  = r_ack_num;
                            n_out.ack_echo = r_cmd.seq;
                            n_ack_num      = r_ack_num + 1'b1;
                        end
                        if (w_fresh) begin
                            w_ram_we     = 1'b1;
                            w_seen_set   = 1'b1;
                            n_out.accept = 1'b1;
                        end
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DIV_LOAD: begin
                if (r_recv == '0) begin
                    n_qpct  = PCT_NONE;
                    n_upct  = PCT_NONE;
                    n_state = S_RPT_OUT;
                end else begin
                    if (!r_pass) begin
                        n_rem = DIV_W'(r_recv) * DIV_W'(PERCENT);
                        n_dsh = DIV_W'(w_total) << (DIV_STEPS - 1);
                    end else begin
                        n_rem = DIV_W'(r_useful) * DIV_W'(PERCENT);
                        n_dsh = DIV_W'(r_recv) << (DIV_STEPS - 1);
                    end
                    n_q     = '0;
                    n_bit   = STEP_W'(DIV_STEPS - 1);
                    n_state = S_DIV_RUN;
                end
            end
            S_DIV_RUN: begin
                if (w_take) begin
                    n_rem = w_trial[DIV_W-1:0];
                end
                n_dsh = r_dsh >> 1;
                n_q   = {r_q[DIV_STEPS-2:0], w_take};
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    if (!r_pass) begin
                        n_qpct  = PCT_W'(n_q);
                        n_pass  = 1'b1;
                        n_state = S_DIV_LOAD;
                    end else begin
                        n_upct  = PCT_W'(n_q);
                        n_state = S_RPT_OUT;
                    end
                end
            end
            S_RPT_OUT: begin
                if (w_out_free) begin
                    n_out                = '0;
                    n_out.report_valid   = 1'b1;
                    n_out.rx_quality_pct = r_qpct;
                    n_out.rx_useful_pct  = r_upct;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_ack_off     <= '0;
            r_ack_num     <= '0;
            r_miss_cnt    <= '0;
            r_useful_cnt  <= '0;
            r_useless_cnt <= '0;
            r_pass        <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_seen[i] <= 1'b0;
            end
        end else begin
            r_out_valid   <= n_out_valid;
            r_ack_off     <= n_ack_off;
            r_ack_num     <= n_ack_num;
            r_miss_cnt    <= n_miss_cnt;
            r_useful_cnt  <= n_useful_cnt;
            r_useless_cnt <= n_useless_cnt;
            r_pass        <= n_pass;
            if (w_seen_set) begin
                r_seen[r_idx] <= 1'b1;
            end
        end
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_out    <= n_out;
        r_recv   <= n_recv;
        r_useful <= n_useful;
        r_miss   <= n_miss;
        r_rem    <= n_rem;
        r_dsh    <= n_dsh;
        r_q      <= n_q;
        r_bit    <= n_bit;
        r_qpct   <= n_qpct;
        r_upct   <= n_upct;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.accept         = r_out.accept;
    assign o_out.ack_out        = r_out.ack_out;
    assign o_out.ack_chan       = r_out.ack_chan;
    assign o_out.ack_seq        = r_out.ack_seq;
    assign o_out.ack_echo       = r_out.ack_echo;
    assign o_out.report_valid   = r_out.report_valid;
    assign o_out.rx_quality_pct = r_out.rx_quality_pct;
    assign o_out.rx_useful_pct  = r_out.rx_useful_pct;

    `RSF_ASSERT(a_div_bound, i_clk, i_rst_n,
        (r_state != S_DIV_RUN) || ({1'b0, r_rem} < {r_dsh, 1'b0}),
        "divider remainder out of range")
    `RSF_ASSERT_NEXT(a_rpt_clear, i_clk, i_rst_n, w_pop && i_cmd.is_report,
        (r_miss_cnt == '0) && (r_useful_cnt == '0) && (r_useless_cnt == '0),
        "counters not cleared by report")
    `RSF_ASSERT(a_rpt_range, i_clk, i_rst_n,
        !(r_out_valid && r_out.report_valid) ||
        (((r_out.rx_quality_pct <= 8'sd100) || (r_out.rx_quality_pct == PCT_NONE)) &&
         ((r_out.rx_useful_pct <= 8'sd100) || (r_out.rx_useful_pct == PCT_NONE)) &&
         !r_out.accept && !r_out.ack_out),
        "bad report word")
    `RSF_ASSERT_NEXT(a_ack_step, i_clk, i_rst_n,
        (r_state == S_LOOK) && w_out_free && r_cmd.is_wack,
        r_ack_num == $past(r_ack_num) + 1'b1,
        "ack sequence did not advance")

endmodule
